FILE: rtl/core/g2l_pkg.sv
// ============================================================================
// g2l_pkg
// Shared types, constants and tables for the Gregorian to lunar date block.
// ============================================================================
package g2l_pkg;

  localparam int MAX_YEARS = 150;

  localparam logic [11:0] BASE_YEAR      = 12'd1900;
  localparam logic [11:0] LAST_GREG_YEAR = 12'd2050;
  localparam logic [8:0]  BASE_YEAR_DAYS = 9'd348;
  localparam logic [15:0] FIRST_OFFSET   = 16'd31;
  localparam logic [3:0]  LAST_MONTH     = 4'd12;

  // bits 15..4 regular month lengths, 3..0 leap month, 16 leap month length
  localparam logic [16:0] YEAR_ROM [0:MAX_YEARS-1] = '{
    17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
    17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
    17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
    17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
    17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
    17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
    17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0, 17'h14573,
    17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
    17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
    17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b5a0, 17'h195a6,
    17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
    17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
    17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
    17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
    17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
    17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
    17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0, 17'h0a4d0,
    17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
    17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0
  };

  typedef struct packed {
    logic load;      // capture the input item
    logic calc;      // form the day offset from 1900-01-31
    logic ystep;     // subtract one lunar year
    logic yhit;      // year found, start month walk
    logic mstep;     // subtract one month
    logic emit;      // register a normal result
    logic emit_oor;  // register an out-of-range result
  } g2l_cmd_t;

  typedef struct packed {
    logic bad;
    logic year_hit;
    logic year_last;
    logic month_hit;
    logic month_last;
  } g2l_status_t;

  function automatic logic [8:0] year_len(input logic [16:0] w);
    logic [8:0] len;
    len = BASE_YEAR_DAYS + 9'($countones(w[15:4]));
    if (w[3:0] != 4'd0) begin
      len = len + (w[16] ? 9'd30 : 9'd29);
    end
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/g2l_ctrl.sv
// ============================================================================
// g2l_ctrl
// Sequencer: day count, year walk, month walk and output handshake.
// ============================================================================
module g2l_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  g2l_pkg::g2l_status_t st,
  output g2l_pkg::g2l_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DAYS  = 2'd1;
  localparam logic [1:0] S_YEAR  = 2'd2;
  localparam logic [1:0] S_MONTH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DAYS;
        end
      end
      S_DAYS: begin
        cmd.calc   = 1'b1;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if (st.bad || (st.year_last && !st.year_hit)) begin
          if (out_free) begin
            cmd.emit_oor = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (st.year_hit) begin
          cmd.yhit   = 1'b1;
          state_next = S_MONTH;
        end else begin
          cmd.ystep = 1'b1;
        end
      end
      S_MONTH: begin
        if (st.month_hit) begin
          if (out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (st.month_last) begin
          if (out_free) begin
            cmd.emit_oor = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.mstep = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit || cmd.emit_oor) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a result is never written over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_oor) |-> (!out_valid || out_ready))
    else $error("result written while output busy");

  // an accepted item always goes to the day count next
  a_accept_days: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DAYS))
    else $error("accepted item did not start day count");

  // no new item is taken during the year walk or the month walk
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR || state == S_MONTH) |-> !cmd.load)
    else $error("item loaded while busy");

endmodule

FILE: rtl/core/g2l_dp.sv
// ============================================================================
// g2l_dp
// Datapath: day offset, year and month subtraction, result registers.
// ============================================================================
module g2l_dp #(
  parameter int TABLE_YEARS = g2l_pkg::MAX_YEARS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  g2l_pkg::g2l_cmd_t    cmd,
  output g2l_pkg::g2l_status_t st,
  input  logic [11:0]          greg_year,
  input  logic [3:0]           greg_month,
  input  logic [4:0]           greg_day,
  output logic [11:0]          lunar_year,
  output logic [3:0]           lunar_month,
  output logic [4:0]           lunar_day,
  output logic                 leap_month,
  output logic                 out_of_range
);

  localparam int YW = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;

  logic [11:0]   gy;
  logic [3:0]    gm;
  logic [4:0]    gd;
  logic [15:0]   off;
  logic          bad;
  logic [YW-1:0] y;
  logic [16:0]   w;
  logic [3:0]    m;
  logic          in_leap;

  logic [7:0]    k;
  logic [8:0]    k3;
  logic [6:0]    leaps;
  logic          gleap;
  logic          range_bad;
  logic [15:0]   days;
  logic [8:0]    ylen;
  logic [11:0]   mbits;
  logic [4:0]    mlen;

  // day count from the registered input
  always_comb begin
    k         = 8'(gy - g2l_pkg::BASE_YEAR);
    k3        = {1'b0, k} + 9'd3;
    leaps     = 7'(k3 >> 2) - {6'd0, (k != 8'd0)};
    gleap     = (k[1:0] == 2'd0) && (k != 8'd0);
    range_bad = (gy < g2l_pkg::BASE_YEAR) || (gy > g2l_pkg::LAST_GREG_YEAR) ||
                (gm == 4'd0) || (gm > g2l_pkg::LAST_MONTH);
    days      = 16'({8'd0, k} * 16'd365) + {9'd0, leaps} +
                {7'd0, g2l_pkg::cum_days(gm)} +
                {15'd0, (gleap && (gm > 4'd2))} + {11'd0, gd};
  end

  assign ylen  = g2l_pkg::year_len(g2l_pkg::YEAR_ROM[8'(y)]);
  assign mbits = w[15:4];
  assign mlen  = in_leap ? (w[16] ? 5'd30 : 5'd29)
                         : (mbits[4'd12 - m] ? 5'd30 : 5'd29);

  always_comb begin
    st            = '0;
    st.bad        = bad;
    st.year_hit   = (off < {7'd0, ylen});
    st.year_last  = (y == YW'(TABLE_YEARS - 1));
    st.month_hit  = (off < {11'd0, mlen});
    st.month_last = (m == g2l_pkg::LAST_MONTH) &&
                    (in_leap || (w[3:0] != g2l_pkg::LAST_MONTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gy <= greg_year;
      gm <= greg_month;
      gd <= greg_day;
    end
    if (cmd.calc) begin
      bad <= range_bad || (days < g2l_pkg::FIRST_OFFSET);
      off <= days - g2l_pkg::FIRST_OFFSET;
      y   <= '0;
    end
    if (cmd.ystep) begin
      off <= off - {7'd0, ylen};
      y   <= y + YW'(1);
    end
    if (cmd.yhit) begin
      w       <= g2l_pkg::YEAR_ROM[8'(y)];
      m       <= 4'd1;
      in_leap <= 1'b0;
    end
    if (cmd.mstep) begin
      off <= off - {11'd0, mlen};
      if (!in_leap && (m == w[3:0])) begin
        in_leap <= 1'b1;
      end else begin
        in_leap <= 1'b0;
        m       <= m + 4'd1;
      end
    end
    if (cmd.emit) begin
      lunar_year   <= g2l_pkg::BASE_YEAR + 12'(y);
      lunar_month  <= m;
      lunar_day    <= 5'(off) + 5'd1;
      leap_month   <= in_leap;
      out_of_range <= 1'b0;
    end else if (cmd.emit_oor) begin
      lunar_year   <= '0;
      lunar_month  <= '0;
      lunar_day    <= '0;
      leap_month   <= 1'b0;
      out_of_range <= 1'b1;
    end
  end

  // a found date always lands on a real month and day
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (lunar_day >= 5'd1 && lunar_day <= 5'd30 &&
                  lunar_month >= 4'd1 && lunar_month <= g2l_pkg::LAST_MONTH))
    else $error("lunar day or month out of range");

  // the year walk never runs past the last table entry
  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ystep |-> (y < YW'(TABLE_YEARS - 1)))
    else $error("year walk past table end");

  // an out-of-range result carries no date
  a_oor_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_oor |=> (out_of_range && lunar_year == 12'd0 && lunar_month == 4'd0 &&
                      lunar_day == 5'd0 && !leap_month))
    else $error("out-of-range result with date fields set");

endmodule

FILE: rtl/core/gregorian_to_lunar_date.sv
// ============================================================================
// gregorian_to_lunar_date
// Steps: accept, day count, year walk over the lunar year index Y (0..149),
// then a month walk of M month steps (0..12); the result is registered.
// One item at a time: the year walk steps one table entry per cycle, and an
// item waits before its result while the output is busy. A new item is taken
// once the previous result is registered.
// Reset: synchronous, clears the sequencer and the output valid; no tables.
// ============================================================================
module gregorian_to_lunar_date #(
  parameter int TABLE_YEARS = g2l_pkg::MAX_YEARS
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] greg_year,
  input  logic [3:0]  greg_month,
  input  logic [4:0]  greg_day,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] lunar_year,
  output logic [3:0]  lunar_month,
  output logic [4:0]  lunar_day,
  output logic        leap_month,
  output logic        out_of_range
);

  // command and status between the sequencer and the datapath
  g2l_pkg::g2l_cmd_t    cmd;
  g2l_pkg::g2l_status_t st;

  // sequencer: idle, day count, year walk, month walk; it also owns the
  // output valid so a finished item waits in the result registers while the
  // next item is accepted
  g2l_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: day offset from 1900-01-31, a running subtraction of lunar
  // year lengths from the constant year table, then of month lengths with
  // the leap month slotted after its regular month
  g2l_dp #(
    .TABLE_YEARS (TABLE_YEARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .greg_year    (greg_year),
    .greg_month   (greg_month),
    .greg_day     (greg_day),
    .lunar_year   (lunar_year),
    .lunar_month  (lunar_month),
    .lunar_day    (lunar_day),
    .leap_month   (leap_month),
    .out_of_range (out_of_range)
  );

endmodule
